// ===== rtl/alu_pkg.sv =====
// ----------------------------------------------------------------------------
// alu_pkg - shared types and codes for the 8/16-bit add/sub/flags ALU
// Request payload structs and operation codes used by the core and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package alu_pkg;

  // Operation codes carried in the kind field
  localparam logic [3:0] KIND_ADD   = 4'd0;
  localparam logic [3:0] KIND_ADC   = 4'd1;
  localparam logic [3:0] KIND_SUB   = 4'd2;
  localparam logic [3:0] KIND_SBC   = 4'd3;
  localparam logic [3:0] KIND_CP    = 4'd4;
  localparam logic [3:0] KIND_INC8  = 4'd5;
  localparam logic [3:0] KIND_DEC8  = 4'd6;
  localparam logic [3:0] KIND_ADD16 = 4'd7;
  localparam logic [3:0] KIND_INC16 = 4'd8;
  localparam logic [3:0] KIND_DEC16 = 4'd9;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  acc_value;
    logic [7:0]  operand_byte;
    logic [15:0] wide_value;
    logic [15:0] wide_operand;
    logic        carry_in;
    logic        zero_in;
  } alu_in_t;

  typedef struct packed {
    logic [7:0]  result_byte;
    logic [15:0] result_wide;
    logic        flag_zero;
    logic        flag_subtract;
    logic        flag_half;
    logic        flag_carry;
    logic        flags_written;
  } alu_out_t;

endpackage

`default_nettype wire

// ===== rtl/alu_exec.sv =====
// ----------------------------------------------------------------------------
// alu_exec - combinational datapath of the add/sub/flags ALU
// Works out the 8-bit or 16-bit result and the Z, N, H, C flags of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module alu_exec (
  input  alu_pkg::alu_in_t  req,
  output alu_pkg::alu_out_t res
);

  logic       cy_add;
  logic       cy_sub;
  logic [8:0] add9;
  logic [4:0] add_lo;
  logic [8:0] sub9;
  logic [4:0] sub_lo;
  logic [7:0] inc8;
  logic [7:0] dec8;
  logic [16:0] add17;
  logic [12:0] add16_lo;
  logic [15:0] inc16;
  logic [15:0] dec16;

  // carry only enters the with-carry forms
  assign cy_add = (req.kind == alu_pkg::KIND_ADC) ? req.carry_in : 1'b0;
  assign cy_sub = (req.kind == alu_pkg::KIND_SBC) ? req.carry_in : 1'b0;

  assign add9   = {1'b0, req.acc_value} + {1'b0, req.operand_byte} + {8'd0, cy_add};
  assign add_lo = {1'b0, req.acc_value[3:0]} + {1'b0, req.operand_byte[3:0]}
                  + {4'd0, cy_add};
  // borrow shows up as the top bit of the wrapped difference
  assign sub9   = {1'b0, req.acc_value} - {1'b0, req.operand_byte} - {8'd0, cy_sub};
  assign sub_lo = {1'b0, req.acc_value[3:0]} - {1'b0, req.operand_byte[3:0]}
                  - {4'd0, cy_sub};

  assign inc8   = req.acc_value + 8'd1;
  assign dec8   = req.acc_value - 8'd1;

  assign add17    = {1'b0, req.wide_value} + {1'b0, req.wide_operand};
  assign add16_lo = {1'b0, req.wide_value[11:0]} + {1'b0, req.wide_operand[11:0]};
  assign inc16    = req.wide_value + 16'd1;
  assign dec16    = req.wide_value - 16'd1;

  always_comb begin
    res               = '0;
    res.flag_zero     = req.zero_in;
    res.flag_carry    = req.carry_in;
    res.flags_written = 1'b1;
    case (req.kind)
      alu_pkg::KIND_ADD, alu_pkg::KIND_ADC: begin
        res.result_byte = add9[7:0];
        res.flag_zero   = (add9[7:0] == 8'd0);
        res.flag_half   = add_lo[4];
        res.flag_carry  = add9[8];
      end
      alu_pkg::KIND_SUB, alu_pkg::KIND_SBC, alu_pkg::KIND_CP: begin
        // compare keeps the accumulator but sets flags as a subtract
        res.result_byte   = (req.kind == alu_pkg::KIND_CP) ? req.acc_value : sub9[7:0];
        res.flag_zero     = (sub9[7:0] == 8'd0);
        res.flag_subtract = 1'b1;
        res.flag_half     = sub_lo[4];
        res.flag_carry    = sub9[8];
      end
      alu_pkg::KIND_INC8: begin
        res.result_byte = inc8;
        res.flag_zero   = (inc8 == 8'd0);
        res.flag_half   = (req.acc_value[3:0] == 4'hf);
      end
      alu_pkg::KIND_DEC8: begin
        res.result_byte   = dec8;
        res.flag_zero     = (dec8 == 8'd0);
        res.flag_subtract = 1'b1;
        res.flag_half     = (req.acc_value[3:0] == 4'h0);
      end
      alu_pkg::KIND_ADD16: begin
        res.result_wide = add17[15:0];
        res.flag_half   = add16_lo[12];
        res.flag_carry  = add17[16];
      end
      alu_pkg::KIND_INC16: begin
        res.result_wide   = inc16;
        res.flags_written = 1'b0;
      end
      alu_pkg::KIND_DEC16: begin
        res.result_wide   = dec16;
        res.flags_written = 1'b0;
      end
      default: begin
        // unused codes pass the operands through untouched
        res.result_byte   = req.acc_value;
        res.result_wide   = req.wide_value;
        res.flags_written = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/cpu_alu_add_sub_flags_core.sv =====
// ----------------------------------------------------------------------------
// cpu_alu_add_sub_flags_core - 8/16-bit add/sub/inc/dec ALU with flags
// Registered ALU: request register, flag/result logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_data and are taken at a rising edge with
//   in_valid high and in_stall low. Each request carries the operation code,
//   the 8-bit and 16-bit operands and the current Z and C flags.
//   Exactly one result leaves on out_valid/out_data per request, in order,
//   taken at an edge with out_valid high and out_stall low.
// Path and rate:
//   out_valid rises once a request has passed the request register and
//   then the result register; a waiting stalled result can hold it back.
//   One request per cycle sustained while out_stall is low; the flag logic
//   between the two registers is parallel adders of up to 17 bits plus a mux.
// Stall:
//   While out_stall holds, a full result register keeps its contents. The
//   request register still takes a new request if it is empty, so one
//   request can sit behind a waiting result; in_stall rises only when both
//   registers are full and the output is stalled.
// Reset:
//   rst_n low (synchronous) empties both registers; no state survives.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_alu_add_sub_flags_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire alu_pkg::alu_in_t  in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      alu_pkg::alu_out_t out_data
);

  // request stage
  logic              req_valid_r;
  logic              req_valid_nxt;
  alu_pkg::alu_in_t  req_data_r;

  // result stage
  logic              res_valid_r;
  logic              res_valid_nxt;
  alu_pkg::alu_out_t res_data_r;
  alu_pkg::alu_out_t res_calc;

  logic res_free;   // result register may load this cycle
  logic req_move;   // request stage hands its request on
  logic in_take;    // new request accepted

  assign res_free = !res_valid_r || !out_stall;
  assign req_move = req_valid_r && res_free;
  assign in_stall = req_valid_r && !res_free;
  assign in_take  = in_valid && !in_stall;

  assign req_valid_nxt = in_take || (req_valid_r && !req_move);
  assign res_valid_nxt = req_move || (res_valid_r && out_stall);

  alu_exec u_exec (
    .req (req_data_r),
    .res (res_calc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_data_r <= in_data;
    end
    if (req_move) begin
      res_data_r <= res_calc;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_data_r;

endmodule

`default_nettype wire

// ===== rtl/alu_checker.sv =====
// ----------------------------------------------------------------------------
// alu_checker - port-level checks for the add/sub/flags ALU
// Watches the result channel for handshake and flag consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module alu_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire alu_pkg::alu_out_t out_data
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // N is only ever set by operations that write the flags
  a_sub_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.flag_subtract |-> out_data.flags_written)
    else $error("N set without flag write");

  // operations that set N are all 8-bit
  a_sub_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.flag_subtract |-> out_data.result_wide == 16'd0)
    else $error("N set on a 16-bit result");

  // unwritten flags leave H clear
  a_half_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.flags_written |-> !out_data.flag_half)
    else $error("H set without flag write");

endmodule

bind cpu_alu_add_sub_flags_core alu_checker u_alu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
